// File: sv/hkrd_pkg.sv
// ----------------------------------------------------------------------------
// hkrd_pkg
// Shared constants and types for the keyboard report differ.
// ----------------------------------------------------------------------------
package hkrd_pkg;

    // Fixed report layout
    localparam int MOD_BITS     = 8;
    localparam int INPUT_SLOTS  = 6;
    localparam int CODE_W       = 8;

    // Defaults for top level parameters
    localparam int KEY_SLOTS_DEF   = 6;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Queue status seen by the front and back parts
    typedef struct packed {
        logic full;
        logic not_empty;
    } hkrd_q_status_t;

endpackage

// File: sv/hkrd_front.sv
// ----------------------------------------------------------------------------
// hkrd_front
// Accepts a report and compares it with the stored previous report; if there
// are events, it pushes one queue word with the event mask and their codes.
// ----------------------------------------------------------------------------
module hkrd_front #(
    parameter int KEY_SLOTS = hkrd_pkg::KEY_SLOTS_DEF,
    parameter int ENTRY_W   = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [7:0]                   modifiers,
    input  logic [7:0]                   key_slot_0,
    input  logic [7:0]                   key_slot_1,
    input  logic [7:0]                   key_slot_2,
    input  logic [7:0]                   key_slot_3,
    input  logic [7:0]                   key_slot_4,
    input  logic [7:0]                   key_slot_5,
    input  logic [7:0]                   key_count,
    input  hkrd_pkg::hkrd_q_status_t     q_status,
    output logic                         push,
    output logic [ENTRY_W-1:0]           push_data
);
    import hkrd_pkg::*;

    localparam int EV_W      = MOD_BITS + KEY_SLOTS + INPUT_SLOTS;
    localparam int MASK_OFS  = MOD_BITS;
    localparam int REL_OFS   = MASK_OFS + EV_W;
    localparam int PRS_OFS   = REL_OFS + CODE_W * KEY_SLOTS;

    logic [CODE_W-1:0]   keys [INPUT_SLOTS];
    logic [INPUT_SLOTS-1:0] active;
    logic [KEY_SLOTS-1:0]   rel_mask;
    logic [INPUT_SLOTS-1:0] prs_mask;
    logic [EV_W-1:0]        ev_mask;
    logic                   accept;

    logic [MOD_BITS-1:0] mods_reg;
    logic [CODE_W-1:0]   prev_reg  [KEY_SLOTS];
    logic [CODE_W-1:0]   prev_next [KEY_SLOTS];

    assign keys[0] = key_slot_0;
    assign keys[1] = key_slot_1;
    assign keys[2] = key_slot_2;
    assign keys[3] = key_slot_3;
    assign keys[4] = key_slot_4;
    assign keys[5] = key_slot_5;

    assign in_stall = q_status.full;
    assign accept   = in_valid && !in_stall;

    // Slots inside the capped count
    always_comb
    begin
        for (int j = 0; j < INPUT_SLOTS; j++)
        begin
            active[j] = (key_count > 8'(j)) && (j < KEY_SLOTS);
        end
    end

    // Releases: stored key not found among the active new slots
    always_comb
    begin
        logic hit;
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            hit = 1'b0;
            for (int j = 0; j < INPUT_SLOTS; j++)
            begin
                if (active[j] && (keys[j] == prev_reg[i]))
                begin
                    hit = 1'b1;
                end
            end
            rel_mask[i] = (prev_reg[i] != '0) && !hit;
        end
    end

    // Presses: active new key not found in any stored slot
    always_comb
    begin
        logic hit;
        for (int j = 0; j < INPUT_SLOTS; j++)
        begin
            hit = 1'b0;
            for (int i = 0; i < KEY_SLOTS; i++)
            begin
                if (prev_reg[i] == keys[j])
                begin
                    hit = 1'b1;
                end
            end
            prs_mask[j] = active[j] && (keys[j] != '0) && !hit;
        end
    end

    assign ev_mask = {prs_mask, rel_mask, modifiers ^ mods_reg};

    // Queue word: new modifiers, event mask, release codes, press codes
    always_comb
    begin
        push_data = '0;
        push_data[MOD_BITS-1:0]        = modifiers;
        push_data[MASK_OFS +: EV_W]    = ev_mask;
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            push_data[REL_OFS + CODE_W*i +: CODE_W] = prev_reg[i];
        end
        for (int j = 0; j < INPUT_SLOTS; j++)
        begin
            push_data[PRS_OFS + CODE_W*j +: CODE_W] = keys[j];
        end
    end

    // A report with no events is absorbed without a queue word
    assign push = accept && (ev_mask != '0);

    // Next stored slots: active slots kept, the rest cleared
    for (genvar g = 0; g < KEY_SLOTS; g++)
    begin : g_store
        if (g < INPUT_SLOTS)
        begin : g_in
            assign prev_next[g] = active[g] ? keys[g] : '0;
        end
        else
        begin : g_extra
            assign prev_next[g] = '0;
        end
    end

    // Previous report state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mods_reg <= '0;
            for (int i = 0; i < KEY_SLOTS; i++)
            begin
                prev_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            mods_reg <= modifiers;
            for (int i = 0; i < KEY_SLOTS; i++)
            begin
                prev_reg[i] <= prev_next[i];
            end
        end
    end

endmodule

// File: sv/hkrd_queue.sv
// ----------------------------------------------------------------------------
// hkrd_queue
// Short FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module hkrd_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = hkrd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  logic [WIDTH-1:0]         push_data,
    input  logic                     pop,
    output logic [WIDTH-1:0]         pop_data,
    output hkrd_pkg::hkrd_q_status_t status
);
    import hkrd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;

    assign status.full      = (count_reg == CNT_W'(DEPTH));
    assign status.not_empty = (count_reg != '0);
    assign pop_data         = data_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: sv/hkrd_back.sv
// ----------------------------------------------------------------------------
// hkrd_back
// Walks the event mask of the current queue word, lowest bit first, and
// emits one event word per cycle, unless stalled, via an output register.
// ----------------------------------------------------------------------------
module hkrd_back #(
    parameter int KEY_SLOTS = hkrd_pkg::KEY_SLOTS_DEF,
    parameter int ENTRY_W   = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  hkrd_pkg::hkrd_q_status_t q_status,
    input  logic [ENTRY_W-1:0]       pop_data,
    output logic                     pop,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     is_modifier,
    output logic [7:0]               event_code,
    output logic                     pressed,
    output logic                     last_event
);
    import hkrd_pkg::*;

    localparam int EV_W     = MOD_BITS + KEY_SLOTS + INPUT_SLOTS;
    localparam int MASK_OFS = MOD_BITS;
    localparam int REL_OFS  = MASK_OFS + EV_W;
    localparam int PRS_OFS  = REL_OFS + CODE_W * KEY_SLOTS;

    logic [ENTRY_W-1:0] cur_reg;
    logic [EV_W-1:0]    pend_reg;
    logic [EV_W-1:0]    pend_next;
    logic               cur_valid_reg;
    logic               cur_valid_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               is_mod_reg;
    logic [CODE_W-1:0]  code_reg;
    logic               pressed_reg;
    logic               last_reg;

    logic [CODE_W-1:0]  ev_code  [EV_W];
    logic [EV_W-1:0]    ev_is_mod;
    logic [EV_W-1:0]    ev_press;
    logic [EV_W-1:0]    low_bit;
    logic               sel_is_mod;
    logic [CODE_W-1:0]  sel_code;
    logic               sel_press;
    logic               sel_last;
    logic               out_free;
    logic               emit;

    // Per-bit event fields of the current word
    for (genvar b = 0; b < EV_W; b++)
    begin : g_ev
        if (b < MOD_BITS)
        begin : g_mod
            assign ev_is_mod[b] = 1'b1;
            assign ev_code[b]   = CODE_W'(b);
            assign ev_press[b]  = cur_reg[b];
        end
        else if (b < MOD_BITS + KEY_SLOTS)
        begin : g_rel
            assign ev_is_mod[b] = 1'b0;
            assign ev_code[b]   = cur_reg[REL_OFS + CODE_W*(b - MOD_BITS) +: CODE_W];
            assign ev_press[b]  = 1'b0;
        end
        else
        begin : g_prs
            assign ev_is_mod[b] = 1'b0;
            assign ev_code[b]   =
                cur_reg[PRS_OFS + CODE_W*(b - MOD_BITS - KEY_SLOTS) +: CODE_W];
            assign ev_press[b]  = 1'b1;
        end
    end

    // Lowest pending event, one-hot select
    assign low_bit  = pend_reg & (~pend_reg + 1'b1);
    assign sel_last = ((pend_reg & ~low_bit) == '0);

    always_comb
    begin
        sel_is_mod = 1'b0;
        sel_code   = '0;
        sel_press  = 1'b0;
        for (int b = 0; b < EV_W; b++)
        begin
            sel_is_mod = sel_is_mod | (ev_is_mod[b] & low_bit[b]);
            sel_code   = sel_code | (ev_code[b] & {CODE_W{low_bit[b]}});
            sel_press  = sel_press | (ev_press[b] & low_bit[b]);
        end
    end

    // Sequencing: emit into a free output slot, load when empty or on final event
    assign out_free = !out_valid_reg || !out_stall;
    assign emit     = cur_valid_reg && out_free;
    assign pop      = q_status.not_empty && (!cur_valid_reg || (emit && sel_last));

    always_comb
    begin
        pend_next      = pend_reg;
        cur_valid_next = cur_valid_reg;
        if (pop)
        begin
            pend_next      = pop_data[MASK_OFS +: EV_W];
            cur_valid_next = 1'b1;
        end
        else if (emit)
        begin
            pend_next      = pend_reg & ~low_bit;
            cur_valid_next = !sel_last;
        end
    end

    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= pop_data;
        end
        if (emit)
        begin
            is_mod_reg  <= sel_is_mod;
            code_reg    <= sel_code;
            pressed_reg <= sel_press;
            last_reg    <= sel_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign is_modifier = is_mod_reg;
    assign event_code  = code_reg;
    assign pressed     = pressed_reg;
    assign last_event  = last_reg;

endmodule

// File: sv/hid_keyboard_report_diff.sv
// ----------------------------------------------------------------------------
// hid_keyboard_report_diff
// Turns boot keyboard reports into modifier and key press/release events.
//
//   channel  direction  handshake            fields
//   in       input      in_valid/in_stall    modifiers, key_slot_0..5, key_count
//   out      output     out_valid/out_stall  is_modifier, event_code, pressed,
//                                            last_event
//
// A report yields up to 8 + KEY_SLOTS + 6 events, emitted one event word per
// cycle by the back sequencer while out_stall is low; a report with no change
// yields no event. The front keeps accepting while the QUEUE_DEPTH word queue
// has room. Reset clears the stored report to zero and empties the queue and
// output.
// ----------------------------------------------------------------------------
module hid_keyboard_report_diff #(
    parameter int KEY_SLOTS   = hkrd_pkg::KEY_SLOTS_DEF,
    parameter int QUEUE_DEPTH = hkrd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] modifiers,
    input  logic [7:0] key_slot_0,
    input  logic [7:0] key_slot_1,
    input  logic [7:0] key_slot_2,
    input  logic [7:0] key_slot_3,
    input  logic [7:0] key_slot_4,
    input  logic [7:0] key_slot_5,
    input  logic [7:0] key_count,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       is_modifier,
    output logic [7:0] event_code,
    output logic       pressed,
    output logic       last_event
);
    import hkrd_pkg::*;

    localparam int EV_W    = MOD_BITS + KEY_SLOTS + INPUT_SLOTS;
    localparam int ENTRY_W = MOD_BITS + EV_W + CODE_W * (KEY_SLOTS + INPUT_SLOTS);

    hkrd_q_status_t     q_status;
    logic               push;
    logic [ENTRY_W-1:0] push_data;
    logic               pop;
    logic [ENTRY_W-1:0] pop_data;

    // Compare and classify
    hkrd_front #(
        .KEY_SLOTS (KEY_SLOTS),
        .ENTRY_W   (ENTRY_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .modifiers  (modifiers),
        .key_slot_0 (key_slot_0),
        .key_slot_1 (key_slot_1),
        .key_slot_2 (key_slot_2),
        .key_slot_3 (key_slot_3),
        .key_slot_4 (key_slot_4),
        .key_slot_5 (key_slot_5),
        .key_count  (key_count),
        .q_status   (q_status),
        .push       (push),
        .push_data  (push_data)
    );

    // Decoupling queue
    hkrd_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    // Event sequencer
    hkrd_back #(
        .KEY_SLOTS (KEY_SLOTS),
        .ENTRY_W   (ENTRY_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_status    (q_status),
        .pop_data    (pop_data),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .is_modifier (is_modifier),
        .event_code  (event_code),
        .pressed     (pressed),
        .last_event  (last_event)
    );

endmodule

// File: tb/hid_keyboard_report_diff_test.sv
// ----------------------------------------------------------------------------
// hid_keyboard_report_diff_test
// Self-checking bench for the keyboard report differ. Reports go in through a
// queue-fed driver with random gaps. A monitor keeps its own copy of the
// stored report and predicts the modifier/key events of every accepted word.
// It then compares each event word at the output, which is stalled at random.
// ----------------------------------------------------------------------------
module hid_keyboard_report_diff_test;

    timeunit 1ns;
    timeprecision 1ps;

    import hkrd_pkg::*;

    localparam int KEY_SLOTS    = KEY_SLOTS_DEF;
    localparam int RANDOM_WORDS = 396;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [7:0]                   mods;
        logic [INPUT_SLOTS-1:0][7:0]  slot;
        logic [7:0]                   count;
    } key_report_t;

    typedef struct packed {
        logic       is_mod;
        logic [7:0] code;
        logic       press;
        logic       last;
    } key_event_t;

    logic       clk;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_stall;
    logic [7:0] modifiers   = '0;
    logic [7:0] key_slot_0  = '0;
    logic [7:0] key_slot_1  = '0;
    logic [7:0] key_slot_2  = '0;
    logic [7:0] key_slot_3  = '0;
    logic [7:0] key_slot_4  = '0;
    logic [7:0] key_slot_5  = '0;
    logic [7:0] key_count   = '0;
    logic       out_valid;
    logic       out_stall   = 1'b0;
    logic       is_modifier;
    logic [7:0] event_code;
    logic       pressed;
    logic       last_event;

    // Predictor copy of the stored report
    logic [7:0] held_mods;
    logic [7:0] held_keys [KEY_SLOTS];

    key_report_t pending_reports [$];
    key_event_t  expected_events [$];
    int          reports_total;
    int          reports_seen = 0;
    int          mismatches   = 0;

    hid_keyboard_report_diff #(
        .KEY_SLOTS (KEY_SLOTS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .modifiers   (modifiers),
        .key_slot_0  (key_slot_0),
        .key_slot_1  (key_slot_1),
        .key_slot_2  (key_slot_2),
        .key_slot_3  (key_slot_3),
        .key_slot_4  (key_slot_4),
        .key_slot_5  (key_slot_5),
        .key_count   (key_count),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .is_modifier (is_modifier),
        .event_code  (event_code),
        .pressed     (pressed),
        .last_event  (last_event)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t ns: mismatch: %s", $time, what);
    endtask

    // Append one report to the driver queue
    function automatic void queue_report(key_report_t r);
        pending_reports.insert(pending_reports.size(), r);
    endfunction

    // Edge events of one report against the held one, then store it
    function automatic void diff_report(key_report_t r);
        int         n;
        bit         found;
        key_event_t ev;
        key_event_t evs [$];
        n = (r.count > INPUT_SLOTS) ? INPUT_SLOTS : int'(r.count);
        if (n > KEY_SLOTS)
            n = KEY_SLOTS;
        // modifier bit changes, bit 0 first
        for (int b = 0; b < MOD_BITS; b++)
        begin
            if (held_mods[b] != r.mods[b])
            begin
                ev = '{is_mod: 1'b1, code: 8'(b), press: r.mods[b], last: 1'b0};
                evs.insert(evs.size(), ev);
            end
        end
        // releases: every held copy missing from the new slots
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            found = 1'b0;
            for (int j = 0; j < n; j++)
                if (r.slot[j] == held_keys[i])
                    found = 1'b1;
            if (held_keys[i] != 8'd0 && !found)
            begin
                ev = '{is_mod: 1'b0, code: held_keys[i], press: 1'b0, last: 1'b0};
                evs.insert(evs.size(), ev);
            end
        end
        // presses: every new copy not held anywhere
        for (int j = 0; j < n; j++)
        begin
            found = 1'b0;
            for (int i = 0; i < KEY_SLOTS; i++)
                if (held_keys[i] == r.slot[j])
                    found = 1'b1;
            if (r.slot[j] != 8'd0 && !found)
            begin
                ev = '{is_mod: 1'b0, code: r.slot[j], press: 1'b1, last: 1'b0};
                evs.insert(evs.size(), ev);
            end
        end
        held_mods = r.mods;
        for (int i = 0; i < KEY_SLOTS; i++)
            held_keys[i] = (i < n) ? r.slot[i] : 8'd0;
        if (evs.size() > 0)
            evs[evs.size() - 1].last = 1'b1;
        foreach (evs[k])
            expected_events.insert(expected_events.size(), evs[k]);
    endfunction

    function automatic key_report_t make_report(
        input logic [7:0] m,
        input logic [7:0] s0, input logic [7:0] s1, input logic [7:0] s2,
        input logic [7:0] s3, input logic [7:0] s4, input logic [7:0] s5,
        input logic [7:0] c
    );
        key_report_t r;
        r.mods  = m;
        r.slot  = {s5, s4, s3, s2, s1, s0};
        r.count = c;
        return r;
    endfunction

    // Mostly a small pool of usage codes so keys collide and repeat
    function automatic logic [7:0] pick_key();
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom);
        return 8'($urandom_range(4, 20));
    endfunction

    // Wait length per word; zero throughout a burst stretch
    function automatic int draw_wait(bit burst);
        return burst ? 0 : int'($urandom_range(0, 15));
    endfunction

    // Input driver
    int in_gap   = 0;
    bit in_burst = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin : drive_reports
        key_report_t r;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap = 0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_reports.size() == 0)
            begin
                in_valid <= 1'b0;
            end
            else
            begin
                r = pending_reports.pop_front();
                modifiers  <= r.mods;
                key_slot_0 <= r.slot[0];
                key_slot_1 <= r.slot[1];
                key_slot_2 <= r.slot[2];
                key_slot_3 <= r.slot[3];
                key_slot_4 <= r.slot[4];
                key_slot_5 <= r.slot[5];
                key_count  <= r.count;
                in_valid   <= 1'b1;
                if ($urandom_range(0, 39) == 0)
                    in_burst = !in_burst;
                in_gap = draw_wait(in_burst);
            end
        end
    end

    // Monitor: predict from accepted reports, then check event words
    int out_hold  = 0;
    bit out_burst = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin : watch_events
        key_report_t r;
        key_event_t  want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_hold = 0;
            held_mods = '0;
            for (int i = 0; i < KEY_SLOTS; i++)
                held_keys[i] = '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                r.mods  = modifiers;
                r.slot  = {key_slot_5, key_slot_4, key_slot_3,
                           key_slot_2, key_slot_1, key_slot_0};
                r.count = key_count;
                diff_report(r);
                reports_seen++;
            end
            if (out_valid && !out_stall)
            begin
                if (expected_events.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected event, code %0d", event_code));
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (is_modifier !== want.is_mod)
                        report_mismatch($sformatf("is_modifier %b, want %b",
                                                  is_modifier, want.is_mod));
                    if (event_code !== want.code)
                        report_mismatch($sformatf("event_code %0d, want %0d",
                                                  event_code, want.code));
                    if (pressed !== want.press)
                        report_mismatch($sformatf("pressed %b, want %b (code %0d)",
                                                  pressed, want.press, want.code));
                    if (last_event !== want.last)
                        report_mismatch($sformatf("last_event %b, want %b (code %0d)",
                                                  last_event, want.last, want.code));
                end
                if ($urandom_range(0, 39) == 0)
                    out_burst = !out_burst;
                out_hold = draw_wait(out_burst);
            end
            if (out_hold > 0)
            begin
                out_hold--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Stimulus and end of run
    initial
    begin : stimulus
        logic [7:0]  gen_mods;
        logic [7:0]  gen_keys [$];
        key_report_t r;

        // directed: extremes, caps, duplicates, no-change reports
        queue_report(make_report(8'h00, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        queue_report(make_report(8'hFF, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9, 8'd6));
        queue_report(make_report(8'h00, 8'hFF, 8'hFF, 8'hFF,
                                 8'hFF, 8'hFF, 8'hFF, 8'd6));
        queue_report(make_report(8'h00, 8'hFF, 8'hFF, 8'hFF,
                                 8'hFF, 8'hFF, 8'hFF, 8'd6));
        queue_report(make_report(8'h00, 8'hFF, 8'hFF, 8'hFF,
                                 8'hFF, 8'hFF, 8'hFF, 8'd0));
        queue_report(make_report(8'h01, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd255));
        queue_report(make_report(8'h01, 8'd1, 8'd2, 8'd3, 8'd0, 8'd0, 8'd0, 8'd7));
        queue_report(make_report(8'h55, 8'd1, 8'd2, 8'd3, 8'd0, 8'd0, 8'd0, 8'd3));
        queue_report(make_report(8'hAA, 8'd10, 8'd10, 8'd10, 8'd11, 8'd0, 8'd0, 8'd4));
        queue_report(make_report(8'hAA, 8'd10, 8'd11, 8'd12, 8'd0, 8'd0, 8'd0, 8'd3));
        queue_report(make_report(8'hAA, 8'd10, 8'd11, 8'd12, 8'd0, 8'd0, 8'd0, 8'd2));
        queue_report(make_report(8'h80, 8'h80, 8'h7F, 8'h01,
                                 8'hFE, 8'd0, 8'd0, 8'd6));
        queue_report(make_report(8'h7F, 8'hFE, 8'h80, 8'h7F,
                                 8'h01, 8'd0, 8'd0, 8'd4));
        queue_report(make_report(8'h00, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));

        // random: mostly typing sequences, some noise
        gen_mods = '0;
        for (int w = 0; w < RANDOM_WORDS; w++)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    // full noise, count often well past six
                    r = key_report_t'({$urandom, $urandom});
                    if ($urandom_range(0, 1) == 0)
                        r.count = 8'($urandom_range(0, 8));
                end
                1, 2:
                begin
                    // tiny code pool: lots of duplicates both sides
                    r.mods = ($urandom_range(0, 3) == 0) ? 8'($urandom) : gen_mods;
                    for (int j = 0; j < INPUT_SLOTS; j++)
                        r.slot[j] = 8'($urandom_range(0, 3) == 0 ? 0 : $urandom_range(4, 7));
                    r.count = 8'($urandom_range(0, 7));
                end
                default:
                begin
                    // one step of ordinary typing
                    case ($urandom_range(0, 6))
                        0, 1:
                            if (gen_keys.size() < INPUT_SLOTS)
                                gen_keys.insert(gen_keys.size(), pick_key());
                        2, 3:
                            if (gen_keys.size() > 0)
                                gen_keys.delete($urandom_range(0, gen_keys.size() - 1));
                        4:
                            gen_mods[$urandom_range(0, 7)] ^= 1'b1;
                        5:
                            if (gen_keys.size() > 0)
                                gen_keys[$urandom_range(0, gen_keys.size() - 1)] = pick_key();
                        default:
                            if ($urandom_range(0, 3) == 0)
                                gen_keys.delete();
                    endcase
                    r.mods = gen_mods;
                    for (int j = 0; j < INPUT_SLOTS; j++)
                    begin
                        if (j < gen_keys.size())
                            r.slot[j] = gen_keys[j];
                        else
                            r.slot[j] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'd0;
                    end
                    r.count = 8'(gen_keys.size());
                    if (gen_keys.size() == INPUT_SLOTS && $urandom_range(0, 2) == 0)
                        r.count = 8'($urandom_range(7, 255));
                end
            endcase
            queue_report(r);
        end
        reports_total = pending_reports.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (reports_seen < reports_total)
            @(posedge clk);
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Hang guard
    initial
    begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
